@@ rtl/lrkc_pkg.sv @@
// ----------------------------------------------------------------------------
// lrkc_pkg
// Types and constants shared by the key cache: request and response
// layouts, command and mode codes, register indexes and LFSR settings.
// ----------------------------------------------------------------------------
package lrkc_pkg;

    localparam int KEY_W  = 31;
    localparam int PAY_W  = 32;
    localparam int FILL_W = 5;
    localparam int LFSR_W = 16;

    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
    localparam logic [LFSR_W-1:0] SEED_RST  = 16'h0001;

    // request commands
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    // replacement modes
    localparam logic MODE_LRU    = 1'b0;
    localparam logic MODE_RANDOM = 1'b1;

    // configuration bus
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam int REG_IDX_LSB = 2;

    // register indexes
    localparam logic REG_REPLACE_MODE = 1'b0;
    localparam logic REG_RANDOM_SEED  = 1'b1;

    typedef struct packed {
        logic             command;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic [PAY_W-1:0]  hit_payload;
        logic              evicted;
        logic [KEY_W-1:0]  evicted_key;
        logic [FILL_W-1:0] fill_count;
    } t_rsp;

endpackage

@@ rtl/lru_random_key_cache.sv @@
// ----------------------------------------------------------------------------
// lru_random_key_cache
// Fully associative cache of message keys with payload handles, evicting
// the least recently used entry or an LFSR-chosen one when full.
// ----------------------------------------------------------------------------
// The cache takes one request per clock cycle while the output side is not
// stalled, and returns one response per request: the request is held in the
// input register, its response in the result register. The work between
// those two registers is the parallel key compare over all ENTRIES entries,
// the victim choice and the recency rank update; every request sees the
// state left by the one before it. The store comes out of reset empty and
// usable at once, with no clearing pass. Configuration (replace_mode at byte
// address 0, random_seed at 4) is to be written only while no request is in
// flight.
module lru_random_key_cache #(
    parameter int ENTRIES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  lrkc_pkg::t_req                i_in_req,
    // response channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output lrkc_pkg::t_rsp                o_out_rsp,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lrkc_pkg::APB_AW-1:0]   paddr,
    input  logic [lrkc_pkg::APB_DW-1:0]   pwdata,
    output logic [lrkc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int BYTE_VALS = 256;
    localparam int BYTE_W = 8;

    // configuration registers
    logic                          r_mode;
    logic [lrkc_pkg::LFSR_W-1:0]   r_seed;
    logic [lrkc_pkg::LFSR_W-1:0]   r_lfsr;
    logic [lrkc_pkg::LFSR_W-1:0]   n_lfsr;

    // cache state
    logic [lrkc_pkg::KEY_W-1:0]    r_key   [ENTRIES];
    logic [lrkc_pkg::PAY_W-1:0]    r_pay   [ENTRIES];
    logic [IW-1:0]                 r_rank  [ENTRIES];
    logic [IW-1:0]                 n_rank  [ENTRIES];
    logic [ENTRIES-1:0]            r_valid;
    logic [ENTRIES-1:0]            n_valid;
    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 n_count;

    // pipeline registers
    logic                          r_req_vld;
    lrkc_pkg::t_req                r_req;
    logic                          r_out_vld;
    lrkc_pkg::t_rsp                r_rsp;
    lrkc_pkg::t_rsp                n_rsp;

    // datapath
    logic                          w_proc;
    logic                          w_insert;
    logic                          w_upd;
    logic [ENTRIES-1:0]            w_match;
    logic                          w_hit;
    logic [IW-1:0]                 w_hit_idx;
    logic [IW-1:0]                 w_free_idx;
    logic [IW-1:0]                 w_lru_idx;
    logic [IW-1:0]                 w_rnd_idx;
    logic [IW-1:0]                 w_victim;
    logic [IW-1:0]                 w_slot;
    logic [IW-1:0]                 w_old_rank;
    logic                          w_full;
    logic                          w_evict;
    logic [lrkc_pkg::LFSR_W-1:0]   w_lfsr_adv;
    logic [IW:0]                   w_rnd_sum;
    logic [CW+lrkc_pkg::FILL_W-1:0] w_fill_ext;
    logic                          w_cfg_wr;

    // residue tables for the two bytes of the LFSR word
    logic [IW-1:0]                 w_mod_lo [BYTE_VALS];
    logic [IW-1:0]                 w_mod_hi [BYTE_VALS];

    for (genvar g = 0; g < BYTE_VALS; g++) begin : g_mod_tbl
        assign w_mod_lo[g] = IW'(g % ENTRIES);
        assign w_mod_hi[g] = IW'((g * BYTE_VALS) % ENTRIES);
    end

    // handshake
    assign w_proc      = r_req_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall  = r_req_vld && !w_proc;
    assign o_out_valid = r_out_vld;
    assign o_out_rsp   = r_rsp;

    // key compare and entry selection
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i] = r_valid[i] && (r_key[i] == r_req.key);
        end
        w_hit = |w_match;

        w_hit_idx  = '0;
        w_free_idx = '0;
        w_lru_idx  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_hit_idx = IW'(i);
            end
            if (!r_valid[i]) begin
                w_free_idx = IW'(i);
            end
            // a full cache holds every rank once, the oldest is the top one
            if (r_rank[i] == IW'(ENTRIES - 1)) begin
                w_lru_idx = IW'(i);
            end
        end
    end

    // random victim: advanced LFSR word reduced modulo the entry count
    always_comb begin
        w_lfsr_adv = r_lfsr >> 1;
        if (r_lfsr[0]) begin
            w_lfsr_adv = w_lfsr_adv ^ lrkc_pkg::LFSR_TAPS;
        end
        w_rnd_sum = {1'b0, w_mod_lo[w_lfsr_adv[BYTE_W-1:0]]}
                  + {1'b0, w_mod_hi[w_lfsr_adv[2*BYTE_W-1:BYTE_W]]};
        if (w_rnd_sum >= (IW+1)'(ENTRIES)) begin
            w_rnd_sum = w_rnd_sum - (IW+1)'(ENTRIES);
        end
        w_rnd_idx = w_rnd_sum[IW-1:0];
    end

    // slot choice and old rank
    assign w_insert = (r_req.command == lrkc_pkg::CMD_INSERT);
    assign w_full   = (r_count == CW'(ENTRIES));
    assign w_evict  = !w_hit && w_insert && w_full;
    assign w_upd    = w_proc && (w_hit || w_insert);
    assign w_victim = (r_mode == lrkc_pkg::MODE_RANDOM) ? w_rnd_idx : w_lru_idx;

    always_comb begin
        if (w_hit) begin
            w_slot     = w_hit_idx;
            w_old_rank = r_rank[w_hit_idx];
        end else if (w_full) begin
            w_slot     = w_victim;
            w_old_rank = r_rank[w_victim];
        end else begin
            w_slot     = w_free_idx;
            w_old_rank = r_count[IW-1:0];
        end
    end

    // next state of ranks, valid bits, count and LFSR
    always_comb begin
        n_valid = r_valid;
        n_count = r_count;
        for (int i = 0; i < ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
            if (w_upd) begin
                if (w_slot == IW'(i)) begin
                    n_rank[i] = '0;
                end else if (r_valid[i] && (r_rank[i] < w_old_rank)) begin
                    n_rank[i] = r_rank[i] + 1'b1;
                end
            end
        end
        if (w_upd && w_insert) begin
            n_valid[w_slot] = 1'b1;
            if (!w_hit && !w_full) begin
                n_count = r_count + 1'b1;
            end
        end

        n_lfsr = r_lfsr;
        if (w_proc && w_evict && (r_mode == lrkc_pkg::MODE_RANDOM)) begin
            n_lfsr = w_lfsr_adv;
        end
        if (w_cfg_wr && (paddr[lrkc_pkg::REG_IDX_LSB] == lrkc_pkg::REG_RANDOM_SEED)) begin
            n_lfsr = (pwdata[lrkc_pkg::LFSR_W-1:0] == '0) ? lrkc_pkg::SEED_RST
                                                          : pwdata[lrkc_pkg::LFSR_W-1:0];
        end
    end

    // response
    assign w_fill_ext = {{lrkc_pkg::FILL_W{1'b0}}, n_count};

    always_comb begin
        n_rsp.hit         = w_hit;
        n_rsp.hit_payload = (w_hit && !w_insert) ? r_pay[w_hit_idx] : '0;
        n_rsp.evicted     = w_evict;
        n_rsp.evicted_key = w_evict ? r_key[w_victim] : '0;
        n_rsp.fill_count  = w_fill_ext[lrkc_pkg::FILL_W-1:0];
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_req_vld <= 1'b1;
        end else if (w_proc) begin
            r_req_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_req <= i_in_req;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_proc) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_rsp <= n_rsp;
        end
    end

    // cache control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= n_rank[i];
            end
        end
    end

    // key and payload store
    always_ff @(posedge i_clk) begin
        if (w_upd && w_insert) begin
            r_key[w_slot] <= r_req.key;
            r_pay[w_slot] <= r_req.payload;
        end
    end

    // configuration registers
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= lrkc_pkg::MODE_LRU;
            r_seed <= lrkc_pkg::SEED_RST;
            r_lfsr <= lrkc_pkg::SEED_RST;
        end else begin
            r_lfsr <= n_lfsr;
            if (w_cfg_wr) begin
                case (paddr[lrkc_pkg::REG_IDX_LSB])
                    lrkc_pkg::REG_REPLACE_MODE: r_mode <= pwdata[0];
                    lrkc_pkg::REG_RANDOM_SEED:  r_seed <= pwdata[lrkc_pkg::LFSR_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // register read back
    always_comb begin
        case (paddr[lrkc_pkg::REG_IDX_LSB])
            lrkc_pkg::REG_REPLACE_MODE: prdata = {{(lrkc_pkg::APB_DW-1){1'b0}}, r_mode};
            lrkc_pkg::REG_RANDOM_SEED:
                prdata = {{(lrkc_pkg::APB_DW-lrkc_pkg::LFSR_W){1'b0}}, r_seed};
            default: prdata = '0;
        endcase
    end

endmodule

@@ bench/lrkc_access_checker.sv @@
// ----------------------------------------------------------------------------
// lrkc_access_checker
// Watches the request, response and configuration channels of the key cache,
// keeps its own copy of the cache contents, recency ranks and LFSR, predicts
// the response of every accepted request and compares it field by field.
// ----------------------------------------------------------------------------
module lrkc_access_checker #(
    parameter int ENTRIES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  lrkc_pkg::t_req              i_in_req,
    // response channel
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  lrkc_pkg::t_rsp              i_out_rsp,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lrkc_pkg::APB_AW-1:0] paddr,
    input  logic [lrkc_pkg::APB_DW-1:0] pwdata,
    input  logic                        pready,
    // status towards the testbench top
    output int                          o_fail_count,
    output int                          o_pending
);

    // shadow cache contents
    logic [lrkc_pkg::KEY_W-1:0]  key_mem [ENTRIES];
    logic [lrkc_pkg::PAY_W-1:0]  pay_mem [ENTRIES];
    logic                        entry_vld [ENTRIES];
    int                          rank_mem [ENTRIES];
    int                          fill_cnt;
    logic [lrkc_pkg::LFSR_W-1:0] lfsr;
    logic                        replace_mode;

    // responses still owed by the cache, oldest first
    lrkc_pkg::t_rsp rsp_expect_q [$];
    int             mismatch_cnt = 0;

    // make one entry most recent, aging every entry that was more recent
    task automatic promote_entry(input int slot, input int old_rank);
        for (int i = 0; i < ENTRIES; i++) begin
            if (i != slot && entry_vld[i] && rank_mem[i] < old_rank) begin
                rank_mem[i]++;
            end
        end
        rank_mem[slot] = 0;
    endtask

    // compute the response of one request and update the shadow state
    task automatic cache_predict(input lrkc_pkg::t_req req, output lrkc_pkg::t_rsp rsp);
        int match_idx;
        int slot;
        int old_rank;
        rsp = '0;
        match_idx = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (match_idx < 0 && entry_vld[i] && key_mem[i] == req.key) begin
                match_idx = i;
            end
        end

        if (match_idx >= 0) begin
            // hit: lookup returns payload, insert overwrites it in place
            rsp.hit = 1'b1;
            if (req.command == lrkc_pkg::CMD_LOOKUP) begin
                rsp.hit_payload = pay_mem[match_idx];
            end else begin
                pay_mem[match_idx] = req.payload;
            end
            promote_entry(match_idx, rank_mem[match_idx]);
        end else if (req.command == lrkc_pkg::CMD_INSERT) begin
            // new key: lowest free entry, else a victim
            slot = -1;
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot < 0 && !entry_vld[i]) begin
                    slot = i;
                end
            end
            if (slot >= 0) begin
                old_rank = fill_cnt;
                if (fill_cnt < ENTRIES) begin
                    fill_cnt++;
                end
            end else begin
                if (replace_mode == lrkc_pkg::MODE_RANDOM) begin
                    lfsr = lfsr[0] ? ((lfsr >> 1) ^ lrkc_pkg::LFSR_TAPS) : (lfsr >> 1);
                    slot = int'(lfsr) % ENTRIES;
                end else begin
                    slot = 0;
                    for (int i = 1; i < ENTRIES; i++) begin
                        if (rank_mem[i] > rank_mem[slot]) begin
                            slot = i;
                        end
                    end
                end
                rsp.evicted     = 1'b1;
                rsp.evicted_key = key_mem[slot];
                old_rank        = rank_mem[slot];
            end
            key_mem[slot]   = req.key;
            pay_mem[slot]   = req.payload;
            entry_vld[slot] = 1'b1;
            promote_entry(slot, old_rank);
        end
        rsp.fill_count = lrkc_pkg::FILL_W'(fill_cnt);
    endtask

    // register write as seen on the configuration port
    task automatic apply_config(input logic [lrkc_pkg::APB_AW-1:0] addr,
                                input logic [lrkc_pkg::APB_DW-1:0] data);
        logic [lrkc_pkg::APB_AW-lrkc_pkg::REG_IDX_LSB-1:0] reg_idx;
        reg_idx = addr[lrkc_pkg::APB_AW-1:lrkc_pkg::REG_IDX_LSB];
        if (reg_idx == lrkc_pkg::REG_REPLACE_MODE) begin
            replace_mode = data[0];
        end else if (reg_idx == lrkc_pkg::REG_RANDOM_SEED) begin
            lfsr = (data[lrkc_pkg::LFSR_W-1:0] != '0) ? data[lrkc_pkg::LFSR_W-1:0]
                                                      : lrkc_pkg::SEED_RST;
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    // sample all channels at the clock edge
    always @(posedge i_clk) begin
        lrkc_pkg::t_rsp want;
        lrkc_pkg::t_rsp pred;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                key_mem[i]   = '0;
                pay_mem[i]   = '0;
                entry_vld[i] = 1'b0;
                rank_mem[i]  = 0;
            end
            fill_cnt     = 0;
            lfsr         = lrkc_pkg::SEED_RST;
            replace_mode = lrkc_pkg::MODE_LRU;
            rsp_expect_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                apply_config(paddr, pwdata);
            end
            // compare before queueing so a response never meets its own request
            if (i_out_valid && !i_out_stall) begin
                if (rsp_expect_q.size() == 0) begin
                    $display("%0t: response with none expected, expected none actual %h",
                             $time, i_out_rsp);
                    mismatch_cnt++;
                end else begin
                    want = rsp_expect_q.pop_front();
                    check_field("hit", 64'(want.hit), 64'(i_out_rsp.hit));
                    check_field("hit_payload", 64'(want.hit_payload),
                                64'(i_out_rsp.hit_payload));
                    check_field("evicted", 64'(want.evicted), 64'(i_out_rsp.evicted));
                    check_field("evicted_key", 64'(want.evicted_key),
                                64'(i_out_rsp.evicted_key));
                    check_field("fill_count", 64'(want.fill_count),
                                64'(i_out_rsp.fill_count));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                cache_predict(i_in_req, pred);
                rsp_expect_q.push_back(pred);
            end
        end
        o_pending    <= rsp_expect_q.size();
        o_fail_count <= mismatch_cnt;
    end

endmodule

@@ bench/tb_lru_random_key_cache.sv @@
// ----------------------------------------------------------------------------
// tb_lru_random_key_cache
// Drives lookups and inserts into the key cache with random gaps and output
// stalls, over both replacement modes and several LFSR seeds; a checker beside
// the cache predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_lru_random_key_cache;

    localparam int ENTRIES         = 16;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 190;
    localparam int KEY_POOL_MAX    = 32;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 400000;

    // idle patterns for either side
    localparam int STYLE_NONE   = 0;
    localparam int STYLE_FULL   = 1;
    localparam int STYLE_SPARSE = 2;

    localparam logic [lrkc_pkg::KEY_W-1:0] KEY_ONES = '1;
    localparam logic [lrkc_pkg::PAY_W-1:0] PAY_ONES = '1;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_in_valid  = 1'b0;
    logic                        o_in_stall;
    lrkc_pkg::t_req              i_in_req    = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    lrkc_pkg::t_rsp              o_out_rsp;
    logic                        psel        = 1'b0;
    logic                        penable     = 1'b0;
    logic                        pwrite      = 1'b0;
    logic [lrkc_pkg::APB_AW-1:0] paddr       = '0;
    logic [lrkc_pkg::APB_DW-1:0] pwdata      = '0;
    logic [lrkc_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int req_style   = STYLE_SPARSE;
    int rsp_style   = STYLE_SPARSE;

    lru_random_key_cache #(
        .ENTRIES (ENTRIES)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    lrkc_access_checker #(
        .ENTRIES (ENTRIES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_req     (i_in_req),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_rsp    (o_out_rsp),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // run-length guard
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    function automatic int draw_wait(input int style);
        case (style)
            STYLE_NONE: return 0;
            STYLE_FULL: return $urandom_range(0, 13);
            default:    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
        endcase
    endfunction

    // response side: random stall before each response
    initial begin
        int n;
        @(posedge i_clk);
        forever begin
            n = draw_wait(rsp_style);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    // one request with a random gap ahead of it
    task automatic send_request(input logic cmd, input logic [lrkc_pkg::KEY_W-1:0] key,
                                input logic [lrkc_pkg::PAY_W-1:0] pay);
        int n;
        lrkc_pkg::t_req req;
        n = draw_wait(req_style);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        req.command = cmd;
        req.key     = key;
        req.payload = pay;
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
    endtask

    // register write: setup cycle then access cycle
    task automatic write_reg(input logic reg_idx, input logic [lrkc_pkg::APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lrkc_pkg::APB_AW'(reg_idx) << lrkc_pkg::REG_IDX_LSB;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // let all responses drain before touching registers
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        // the pending count is registered, so it lags the last accepted request
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        logic [lrkc_pkg::KEY_W-1:0] key_pool [KEY_POOL_MAX];
        logic [lrkc_pkg::KEY_W-1:0] key;
        logic [31:0]                rnd;
        logic                       mode;
        logic [15:0]                seed;
        logic                       cmd;
        int                         pool_size;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty miss, key extremes, in-place update, fill, lru eviction
        send_request(lrkc_pkg::CMD_LOOKUP, '0, PAY_ONES);
        send_request(lrkc_pkg::CMD_INSERT, '0, '0);
        send_request(lrkc_pkg::CMD_INSERT, KEY_ONES, PAY_ONES);
        send_request(lrkc_pkg::CMD_LOOKUP, KEY_ONES, '0);
        send_request(lrkc_pkg::CMD_LOOKUP, '0, '0);
        send_request(lrkc_pkg::CMD_INSERT, KEY_ONES, 32'h1234_5678);
        send_request(lrkc_pkg::CMD_LOOKUP, KEY_ONES, '0);
        for (int i = 1; i <= ENTRIES - 2; i++) begin
            send_request(lrkc_pkg::CMD_INSERT, lrkc_pkg::KEY_W'(i), $urandom);
        end
        send_request(lrkc_pkg::CMD_INSERT, 31'h5555_5555, 32'hAAAA_AAAA);
        send_request(lrkc_pkg::CMD_LOOKUP, 31'h2AAA_AAAA, '0);

        // random phases over modes and seeds, extremes of the seed included
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    mode = lrkc_pkg::MODE_RANDOM;
                    seed = 16'h0000;
                end
                1: begin
                    mode = lrkc_pkg::MODE_RANDOM;
                    seed = 16'hFFFF;
                end
                2: begin
                    mode = lrkc_pkg::MODE_LRU;
                    seed = 16'($urandom_range(0, 65535));
                end
                3: begin
                    mode = lrkc_pkg::MODE_RANDOM;
                    seed = 16'($urandom_range(1, 65535));
                end
                4: begin
                    mode = lrkc_pkg::MODE_RANDOM;
                    seed = lrkc_pkg::SEED_RST;
                end
                default: begin
                    mode = lrkc_pkg::MODE_LRU;
                    seed = 16'($urandom_range(1, 65535));
                end
            endcase
            write_reg(lrkc_pkg::REG_REPLACE_MODE, lrkc_pkg::APB_DW'(mode));
            write_reg(lrkc_pkg::REG_RANDOM_SEED, lrkc_pkg::APB_DW'(seed));

            // small pools give hits, larger ones keep the cache evicting
            pool_size = $urandom_range(10, KEY_POOL_MAX);
            for (int i = 0; i < KEY_POOL_MAX; i++) begin
                rnd = $urandom;
                key_pool[i] = rnd[lrkc_pkg::KEY_W-1:0];
            end
            req_style = ph % 3;
            rsp_style = (ph + 1) % 3;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                cmd = ($urandom_range(0, 1) == 1) ? lrkc_pkg::CMD_INSERT
                                                  : lrkc_pkg::CMD_LOOKUP;
                if ($urandom_range(0, 9) == 0) begin
                    rnd = $urandom;
                    key = rnd[lrkc_pkg::KEY_W-1:0];
                end else begin
                    key = key_pool[$urandom_range(0, pool_size - 1)];
                end
                send_request(cmd, key, $urandom);
            end
        end

        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/lrkc_pkg.sv
rtl/lru_random_key_cache.sv
bench/lrkc_access_checker.sv
bench/tb_lru_random_key_cache.sv
